>>> design/assert_macros.svh
// Shared assertion macros for the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

>>> design/lafi_pkg.sv
package lafi_pkg;

    // Field and datapath widths
    localparam int DATA_W       = 16;
    localparam int OUT_W        = 36;
    localparam int WGT_W        = 32;
    localparam int PROD_W       = OUT_W + DATA_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int SAT_IN_W     = ACC_W + 2;
    localparam int FRAC_W       = 15;
    localparam int MU_W         = 6;
    localparam int MAX_TAPS     = 4;
    localparam int REF_IDX_W    = 2;
    localparam int TAPS_DEFAULT = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_TAP0 = 3'd0,
        REG_REF_TAP1 = 3'd1,
        REG_REF_TAP2 = 3'd2,
        REG_REF_TAP3 = 3'd3,
        REG_MU_SHIFT = 3'd4
    } cfg_reg_t;

    // Reset values
    localparam logic signed [DATA_W-1:0] REF_TAP_RST = 16'sd8192;
    localparam logic [MU_W-1:0]          MU_RST      = 6'd27;
    localparam logic [MU_W-1:0]          MU_MIN      = 6'd15;

    // Saturate to the 36-bit result range
    function automatic logic signed [OUT_W-1:0] sat36(input logic signed [SAT_IN_W-1:0] v);
        logic fits;
        fits = (&v[SAT_IN_W-1:OUT_W-1]) | ~(|v[SAT_IN_W-1:OUT_W-1]);
        if (fits)
            return v[OUT_W-1:0];
        else if (v[SAT_IN_W-1])
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

    // Saturate to the 32-bit weight range
    function automatic logic signed [WGT_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic fits;
        fits = (&v[SAT_IN_W-1:WGT_W-1]) | ~(|v[SAT_IN_W-1:WGT_W-1]);
        if (fits)
            return v[WGT_W-1:0];
        else if (v[SAT_IN_W-1])
            return {1'b1, {(WGT_W-1){1'b0}}};
        else
            return {1'b0, {(WGT_W-1){1'b1}}};
    endfunction

endpackage

>>> design/lms_adaptive_fir_identifier.sv
// Channel   Handshake                Payload
// -------   ----------------------   ------------------------------------------
// input     in_valid / in_ready      sample_in
// result    out_valid / out_ready    error_out, estimate_out, weight0..3_out
// config    cfg_valid / cfg_ready    cfg_index, cfg_data (cfg_ready always high)
//
// A sample runs from transfer to result load through S_MAC, S_DRAIN, S_ERR,
// S_UPD, S_UDRAIN and S_DONE: the single 36x16 multiplier issues one product
// per cycle in S_MAC (d, then y) and in S_UPD (the weight steps).
// in_ready is high only between items; a waiting result sits in the output
// register and the next sample can start behind it.
// Async active-low reset clears control, taps, weights, out_valid; presets config.
module lms_adaptive_fir_identifier #(
    parameter int TAPS = lafi_pkg::TAPS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // sample channel
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [lafi_pkg::DATA_W-1:0]      sample_in,
    // result channel
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [lafi_pkg::OUT_W-1:0]       error_out,
    output logic signed [lafi_pkg::OUT_W-1:0]       estimate_out,
    output logic signed [lafi_pkg::WGT_W-1:0]       weight0_out,
    output logic signed [lafi_pkg::WGT_W-1:0]       weight1_out,
    output logic signed [lafi_pkg::WGT_W-1:0]       weight2_out,
    output logic signed [lafi_pkg::WGT_W-1:0]       weight3_out,
    // configuration channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [lafi_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lafi_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int IW = $clog2(TAPS);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MAC    = 7'b0000010,
        S_DRAIN  = 7'b0000100,
        S_ERR    = 7'b0001000,
        S_UPD    = 7'b0010000,
        S_UDRAIN = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    // What the product register holds
    typedef enum logic [1:0] {
        K_D = 2'd0,
        K_Y = 2'd1,
        K_W = 2'd2
    } kind_t;

    state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic phase_reg, phase_next;       // 0: reference taps, 1: adaptive weights

    // Configuration registers
    logic signed [lafi_pkg::DATA_W-1:0] ref_tap_reg [lafi_pkg::MAX_TAPS];
    logic [lafi_pkg::MU_W-1:0]          mu_reg;

    // Tap line and weights
    logic signed [lafi_pkg::DATA_W-1:0] x_reg [TAPS];
    logic signed [lafi_pkg::WGT_W-1:0]  w_reg [TAPS];

    // Product pipeline stage
    logic signed [lafi_pkg::PROD_W-1:0] prod_reg;
    logic                               pvld_reg, pvld_next;
    kind_t                              pkind_reg, pkind_next;
    logic [IW-1:0]                      ptag_reg;

    // Accumulators and error
    logic signed [lafi_pkg::ACC_W-1:0] d_reg;
    logic signed [lafi_pkg::ACC_W-1:0] acc_reg;
    logic signed [lafi_pkg::OUT_W-1:0] e_reg;
    logic signed [lafi_pkg::OUT_W-1:0] y_reg;

    // Output register
    logic                               out_valid_reg;
    logic signed [lafi_pkg::OUT_W-1:0]  eout_reg;
    logic signed [lafi_pkg::OUT_W-1:0]  yout_reg;
    logic signed [lafi_pkg::WGT_W-1:0]  wout_reg [lafi_pkg::MAX_TAPS];

    logic in_xfer;
    logic out_load;
    logic idx_last;

    logic signed [lafi_pkg::OUT_W-1:0]    mul_a;
    logic signed [lafi_pkg::DATA_W-1:0]   mul_b;
    logic signed [lafi_pkg::PROD_W-1:0]   mul_p;
    logic [IW-1:0]                        w_addr;
    logic signed [lafi_pkg::WGT_W-1:0]    w_rd;
    logic [lafi_pkg::MU_W-1:0]            sh_val;
    logic signed [lafi_pkg::PROD_W-1:0]   delta;
    logic signed [lafi_pkg::ACC_W-1:0]    y_full;
    logic signed [lafi_pkg::OUT_W-1:0]    y_sat;
    logic signed [lafi_pkg::SAT_IN_W-1:0] e_full;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign in_xfer   = in_valid && in_ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign idx_last  = (idx_reg == IW'(TAPS - 1));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        pvld_next  = 1'b0;
        pkind_next = K_D;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_MAC;
                    idx_next   = '0;
                    phase_next = 1'b0;
                end
            end
            S_MAC:
            begin
                pvld_next  = 1'b1;
                pkind_next = phase_reg ? K_Y : K_D;
                if (idx_last)
                begin
                    idx_next = '0;
                    if (phase_reg)
                        state_next = S_DRAIN;
                    else
                        phase_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_ERR;
            end
            S_ERR:
            begin
                state_next = S_UPD;
                idx_next   = '0;
            end
            S_UPD:
            begin
                pvld_next  = 1'b1;
                pkind_next = K_W;
                if (idx_last)
                    state_next = S_UDRAIN;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_UDRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Shared multiplier operand select
    assign w_addr = (state_reg == S_MAC) ? idx_reg : ptag_reg;
    assign w_rd   = w_reg[w_addr];

    always_comb
    begin
        if (state_reg == S_UPD)
            mul_a = e_reg;
        else if (phase_reg)
            mul_a = lafi_pkg::OUT_W'(w_rd);
        else
            mul_a = lafi_pkg::OUT_W'(ref_tap_reg[lafi_pkg::REF_IDX_W'(idx_reg)]);
    end

    assign mul_b = x_reg[idx_reg];
    assign mul_p = mul_a * mul_b;

    // Weight step: mu_shift below 15 acts as 15
    assign sh_val = (mu_reg < lafi_pkg::MU_MIN) ? '0 : mu_reg - lafi_pkg::MU_MIN;
    assign delta  = prod_reg >>> sh_val;

    // Estimate and error
    assign y_full = acc_reg >>> lafi_pkg::FRAC_W;
    assign y_sat  = lafi_pkg::sat36(lafi_pkg::SAT_IN_W'(y_full));
    assign e_full = lafi_pkg::SAT_IN_W'(d_reg) - lafi_pkg::SAT_IN_W'(y_sat);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            phase_reg <= 1'b0;
            pvld_reg  <= 1'b0;
            pkind_reg <= K_D;
            ptag_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            pvld_reg  <= pvld_next;
            pkind_reg <= pkind_next;
            ptag_reg  <= idx_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < lafi_pkg::MAX_TAPS; n++)
                ref_tap_reg[n] <= lafi_pkg::REF_TAP_RST;
            mu_reg <= lafi_pkg::MU_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lafi_pkg::cfg_reg_t'(cfg_index))
                lafi_pkg::REG_REF_TAP0: ref_tap_reg[0] <= cfg_data;
                lafi_pkg::REG_REF_TAP1: ref_tap_reg[1] <= cfg_data;
                lafi_pkg::REG_REF_TAP2: ref_tap_reg[2] <= cfg_data;
                lafi_pkg::REG_REF_TAP3: ref_tap_reg[3] <= cfg_data;
                lafi_pkg::REG_MU_SHIFT: mu_reg <= cfg_data[lafi_pkg::MU_W-1:0];
                default: ;
            endcase
        end
    end

    // Tap line shifts on each sample transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < TAPS; n++)
                x_reg[n] <= '0;
        end
        else if (in_xfer)
        begin
            x_reg[0] <= sample_in;
            for (int n = 1; n < TAPS; n++)
                x_reg[n] <= x_reg[n-1];
        end
    end

    // Adaptive weights, one saturating step per product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < TAPS; n++)
                w_reg[n] <= '0;
        end
        else if (pvld_reg && (pkind_reg == K_W))
        begin
            w_reg[ptag_reg] <= lafi_pkg::sat32(lafi_pkg::SAT_IN_W'(w_rd)
                                               + lafi_pkg::SAT_IN_W'(delta));
        end
    end

    // Product register and accumulators
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (in_xfer)
        begin
            d_reg   <= '0;
            acc_reg <= '0;
        end
        else if (pvld_reg)
        begin
            case (pkind_reg)
                K_D:     d_reg   <= d_reg + lafi_pkg::ACC_W'(prod_reg);
                K_Y:     acc_reg <= acc_reg + lafi_pkg::ACC_W'(prod_reg);
                default: ;
            endcase
        end
        if (state_reg == S_ERR)
        begin
            y_reg <= y_sat;
            e_reg <= lafi_pkg::sat36(e_full);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            eout_reg <= e_reg;
            yout_reg <= y_reg;
            for (int n = 0; n < lafi_pkg::MAX_TAPS; n++)
            begin
                if (n < TAPS)
                    wout_reg[n] <= w_reg[IW'(n)];
                else
                    wout_reg[n] <= '0;
            end
        end
    end

    assign error_out    = eout_reg;
    assign estimate_out = yout_reg;
    assign weight0_out  = wout_reg[0];
    assign weight1_out  = wout_reg[1];
    assign weight2_out  = wout_reg[2];
    assign weight3_out  = wout_reg[3];

endmodule

>>> design/lafi_checker.sv
`include "assert_macros.svh"

module lafi_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [lafi_pkg::OUT_W-1:0]   error_out,
    input logic                                cfg_ready
);

    // A stalled result holds its value
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(error_out))

    // Busy after a sample transfer
    `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready ##1 !in_ready)

    // A new result only comes out of a busy cycle
    `ASSERT_SAME(a_result_from_work, clk, rst_n, $rose(out_valid), $past(!in_ready))

    // Configuration is never back-pressured
    `ASSERT_SAME(a_cfg_open, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind lms_adaptive_fir_identifier lafi_checker u_lafi_checker (.*);
